/* src/plsf_pkg.sv */
// shared types, constants and saturating arithmetic helpers for the polynomial fit
package plsf_pkg;

    localparam logic [63:0] ONE_Q16  = 64'd65536;
    localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // register index taken from paddr
    localparam logic REG_FIT_DEGREE = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    // numerator bits of the quotient unit: |a| * 2^32 fits in 96 bits
    localparam int DIV_BITS = 96;

    typedef struct packed {
        logic               last;
        logic [1:0]         degree;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } sample_t;

    typedef struct packed {
        logic        start;
        logic        sh32;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] value;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } div_rsp_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat_res_t;

    function automatic logic [63:0] magn(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // apply a sign to a 128-bit magnitude and clip to 64 bits signed
    function automatic sat_res_t sat_mag(input logic [127:0] m, input logic neg);
        sat_res_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (m > {64'd0, SIGN64}) begin
                r.sat = 1'b1;
                r.val = SIGN64;
            end else if (m == {64'd0, SIGN64}) begin
                r.val = SIGN64;
            end else begin
                r.val = 64'd0 - m[63:0];
            end
        end else begin
            if (m > {64'd0, MAXPOS64}) begin
                r.sat = 1'b1;
                r.val = MAXPOS64;
            end else begin
                r.val = m[63:0];
            end
        end
        return r;
    endfunction

    function automatic sat_res_t sat_add(input logic [63:0] a, input logic [63:0] b);
        sat_res_t r;
        logic [63:0] s;
        s = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? SIGN64 : MAXPOS64) : s;
        return r;
    endfunction

    function automatic sat_res_t sat_sub(input logic [63:0] a, input logic [63:0] b);
        sat_res_t r;
        logic [63:0] s;
        s = a - b;
        r.sat = (a[63] != b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? SIGN64 : MAXPOS64) : s;
        return r;
    endfunction

endpackage

/* src/plsf_queue.sv */
// short sample queue between the accepting front and the fitting back end
module plsf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  plsf_pkg::sample_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output plsf_pkg::sample_t  out_data
);
    localparam int DEPTH = plsf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plsf_pkg::sample_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                entry_reg[wr_ptr_reg] <= in_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/plsf_mul.sv */
// 64x64 fixed point multiplier from four 32x32 partial products, rounded and clipped
module plsf_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  plsf_pkg::mul_req_t  req,
    output plsf_pkg::mul_rsp_t  rsp
);
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg, sh32_reg, busy_reg;
    logic [2:0]   step_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pos_reg;
    logic [127:0] acc_reg;
    plsf_pkg::sat_res_t clip;

    assign clip = plsf_pkg::sat_mag(acc_reg, neg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            rsp      <= '0;
        end else begin
            rsp.done <= 1'b0;
            if (req.start) begin
                ma_reg   <= plsf_pkg::magn(req.a);
                mb_reg   <= plsf_pkg::magn(req.b);
                neg_reg  <= req.a[63] ^ req.b[63];
                sh32_reg <= req.sh32;
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                // partial product in steps 0..3, summed in the following step
                if (step_reg <= 3'd3) begin
                    pp_reg  <= (step_reg[1] ? {32'd0, ma_reg[63:32]} : {32'd0, ma_reg[31:0]})
                             * (step_reg[0] ? {32'd0, mb_reg[63:32]} : {32'd0, mb_reg[31:0]});
                    pos_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                end
                if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                    acc_reg <= acc_reg + ({64'd0, pp_reg} << {pos_reg, 5'd0});
                end
                if (step_reg == 3'd5) begin
                    // round half away from zero on the magnitude
                    acc_reg <= sh32_reg ? ((acc_reg + (128'd1 << 31)) >> 32)
                                        : ((acc_reg + (128'd1 << 15)) >> 16);
                end
                if (step_reg == 3'd6) begin
                    rsp.done  <= 1'b1;
                    rsp.sat   <= clip.sat;
                    rsp.value <= clip.val;
                    busy_reg  <= 1'b0;
                end
            end
        end
    end

endmodule

/* src/plsf_div.sv */
// restoring divider for round(a * 2^32 / b), one quotient bit per cycle
module plsf_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  plsf_pkg::div_req_t  req,
    output plsf_pkg::div_rsp_t  rsp
);
    localparam int NB    = plsf_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(NB + 1);

    typedef enum logic [1:0] {DV_IDLE, DV_ITER, DV_ROUND, DV_SAT} dv_state_t;

    dv_state_t      state_reg;
    logic [63:0]    d_reg, r_reg;
    logic [NB-1:0]  num_reg;
    logic [NB:0]    q_reg;
    logic           neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [64:0]    r_shift;
    logic           fits;
    plsf_pkg::sat_res_t clip;

    assign r_shift = {r_reg, num_reg[NB-1]};
    assign fits    = (r_shift >= {1'b0, d_reg});
    assign clip    = plsf_pkg::sat_mag({{(127 - NB){1'b0}}, q_reg}, neg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            rsp       <= '0;
        end else begin
            rsp.done <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (req.start) begin
                        d_reg     <= plsf_pkg::magn(req.b);
                        num_reg   <= {plsf_pkg::magn(req.a), 32'd0};
                        q_reg     <= '0;
                        r_reg     <= '0;
                        neg_reg   <= req.a[63] ^ req.b[63];
                        cnt_reg   <= CNT_W'(NB);
                        state_reg <= DV_ITER;
                    end
                end
                DV_ITER: begin
                    r_reg   <= fits ? 64'(r_shift - {1'b0, d_reg}) : r_shift[63:0];
                    q_reg   <= {q_reg[NB-1:0], fits};
                    num_reg <= {num_reg[NB-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= DV_ROUND;
                    end
                end
                DV_ROUND: begin
                    if (r_reg >= d_reg - r_reg) begin
                        q_reg <= q_reg + 1'b1;
                    end
                    state_reg <= DV_SAT;
                end
                DV_SAT: begin
                    rsp.done  <= 1'b1;
                    rsp.value <= (d_reg == '0) ? '0 : clip.val;
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

endmodule

/* src/plsf_back.sv */
// back end: accumulates power and moment sums, runs the LDL^T solve and emits coefficients
module plsf_back #(
    parameter int MAX_DEGREE = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  plsf_pkg::sample_t  q_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);
    localparam int NC   = MAX_DEGREE + 1;
    localparam int NPOW = 2 * MAX_DEGREE + 1;
    localparam int DW   = $clog2(NC);
    localparam int PW   = $clog2(NPOW);
    localparam int CW   = DW + 1;

    typedef enum logic [4:0] {
        IDLE, ACC_ADD, ACC_MY, ACC_NEXT, ACC_PX, ACC_END,
        FAC_INIT, FAC_K, FAC_K2, FAC_T, FAC_T2, FAC_U, FAC_END, FAC_DIV, FAC_ADV,
        FWD_INIT, FWD_K, FWD_K2, FWD_U, FWD_ADV,
        SCL, SCL2, SCL_W,
        BWD_INIT, BWD_K, BWD_K2, BWD_U, BWD_ADV,
        EMIT
    } state_t;

    state_t state_reg;

    logic [63:0] pow_reg [NPOW];
    logic [63:0] mom_reg [NC];
    logic [63:0] fac_reg [NC][NC];
    logic [63:0] sol_reg [NC];
    logic        ovf_reg, sing_reg, last_reg;
    logic [63:0] x_reg, y_reg, p_reg, a_reg;
    logic [PW-1:0] acc_k_reg;
    logic [CW-1:0] d_reg, n_reg, i_reg, j_reg, k_reg;

    plsf_pkg::mul_req_t mul_req_reg;
    plsf_pkg::mul_rsp_t mul_rsp;
    plsf_pkg::div_req_t div_req_reg;
    plsf_pkg::div_rsp_t div_rsp;

    logic [DW-1:0] ii, jj, kk;
    logic [PW-1:0] pidx;
    plsf_pkg::sat_res_t add_p, add_m, sub_a;
    logic out_free;

    assign ii   = i_reg[DW-1:0];
    assign jj   = j_reg[DW-1:0];
    assign kk   = k_reg[DW-1:0];
    assign pidx = PW'(ii) + PW'(jj);
    assign add_p = plsf_pkg::sat_add(pow_reg[acc_k_reg], p_reg);
    assign add_m = plsf_pkg::sat_add(mom_reg[acc_k_reg[DW-1:0]], mul_rsp.value);
    assign sub_a = plsf_pkg::sat_sub(a_reg, mul_rsp.value);
    assign out_free = !m_tvalid || m_tready;
    assign q_ready  = (state_reg == IDLE);

    plsf_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req_reg), .rsp(mul_rsp));
    plsf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req_reg), .rsp(div_rsp));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_tvalid    <= 1'b0;
            ovf_reg     <= 1'b0;
            sing_reg    <= 1'b0;
            mul_req_reg <= '0;
            div_req_reg <= '0;
            for (int e = 0; e < NPOW; e++) pow_reg[e] <= '0;
            for (int e = 0; e < NC; e++) mom_reg[e] <= '0;
        end else begin
            mul_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
            if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (q_valid) begin
                        x_reg     <= {{32{q_data.x[31]}}, q_data.x};
                        y_reg     <= {{32{q_data.y[31]}}, q_data.y};
                        last_reg  <= q_data.last;
                        d_reg     <= CW'(q_data.degree);
                        p_reg     <= plsf_pkg::ONE_Q16;
                        acc_k_reg <= '0;
                        state_reg <= ACC_ADD;
                    end
                end
                // power term into its sum, moment product when k <= d
                ACC_ADD: begin
                    pow_reg[acc_k_reg] <= add_p.val;
                    ovf_reg <= ovf_reg | add_p.sat;
                    if (8'(acc_k_reg) <= 8'(d_reg)) begin
                        mul_req_reg <= '{start: 1'b1, sh32: 1'b0, a: p_reg, b: y_reg};
                        state_reg   <= ACC_MY;
                    end else begin
                        state_reg <= ACC_NEXT;
                    end
                end
                ACC_MY: begin
                    if (mul_rsp.done) begin
                        mom_reg[acc_k_reg[DW-1:0]] <= add_m.val;
                        ovf_reg   <= ovf_reg | add_m.sat | mul_rsp.sat;
                        state_reg <= ACC_NEXT;
                    end
                end
                ACC_NEXT: begin
                    if (8'(acc_k_reg) == 8'({d_reg, 1'b0})) begin
                        state_reg <= ACC_END;
                    end else begin
                        mul_req_reg <= '{start: 1'b1, sh32: 1'b0, a: p_reg, b: x_reg};
                        acc_k_reg   <= acc_k_reg + 1'b1;
                        state_reg   <= ACC_PX;
                    end
                end
                ACC_PX: begin
                    if (mul_rsp.done) begin
                        p_reg     <= mul_rsp.value;
                        ovf_reg   <= ovf_reg | mul_rsp.sat;
                        state_reg <= ACC_ADD;
                    end
                end
                ACC_END: begin
                    if (last_reg) begin
                        n_reg     <= d_reg + 1'b1;
                        sing_reg  <= 1'b0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= FAC_INIT;
                    end else begin
                        state_reg <= IDLE;
                    end
                end
                // factorisation, diagonal handled as the i == j row
                FAC_INIT: begin
                    a_reg     <= pow_reg[pidx];
                    k_reg     <= '0;
                    state_reg <= FAC_K;
                end
                FAC_K: begin
                    if (k_reg < j_reg) begin
                        mul_req_reg.a <= fac_reg[ii][kk];
                        state_reg     <= FAC_K2;
                    end else begin
                        state_reg <= FAC_END;
                    end
                end
                FAC_K2: begin
                    mul_req_reg.b     <= fac_reg[jj][kk];
                    mul_req_reg.sh32  <= 1'b1;
                    mul_req_reg.start <= 1'b1;
                    state_reg         <= FAC_T;
                end
                FAC_T: begin
                    if (mul_rsp.done) begin
                        mul_req_reg.a <= mul_rsp.value;
                        state_reg     <= FAC_T2;
                    end
                end
                FAC_T2: begin
                    mul_req_reg.b     <= fac_reg[kk][kk];
                    mul_req_reg.start <= 1'b1;
                    state_reg         <= FAC_U;
                end
                FAC_U: begin
                    if (mul_rsp.done) begin
                        a_reg     <= sub_a.val;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= FAC_K;
                    end
                end
                FAC_END: begin
                    if (i_reg == j_reg) begin
                        if (a_reg == '0) begin
                            sing_reg  <= 1'b1;
                            k_reg     <= '0;
                            state_reg <= EMIT;
                        end else begin
                            fac_reg[jj][jj] <= a_reg;
                            state_reg       <= FAC_ADV;
                        end
                    end else begin
                        div_req_reg <= '{start: 1'b1, a: a_reg, b: fac_reg[jj][jj]};
                        state_reg   <= FAC_DIV;
                    end
                end
                FAC_DIV: begin
                    if (div_rsp.done) begin
                        fac_reg[ii][jj] <= div_rsp.value;
                        state_reg       <= FAC_ADV;
                    end
                end
                FAC_ADV: begin
                    if (i_reg + 1'b1 < n_reg) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= FAC_INIT;
                    end else if (j_reg + 1'b1 < n_reg) begin
                        j_reg     <= j_reg + 1'b1;
                        i_reg     <= j_reg + 1'b1;
                        state_reg <= FAC_INIT;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= FWD_INIT;
                    end
                end
                // forward substitution through L
                FWD_INIT: begin
                    a_reg     <= mom_reg[ii];
                    k_reg     <= '0;
                    state_reg <= FWD_K;
                end
                FWD_K: begin
                    if (k_reg < i_reg) begin
                        mul_req_reg.a <= fac_reg[ii][kk];
                        state_reg     <= FWD_K2;
                    end else begin
                        sol_reg[ii] <= a_reg;
                        state_reg   <= FWD_ADV;
                    end
                end
                FWD_K2: begin
                    mul_req_reg.b     <= sol_reg[kk];
                    mul_req_reg.sh32  <= 1'b1;
                    mul_req_reg.start <= 1'b1;
                    state_reg         <= FWD_U;
                end
                FWD_U: begin
                    if (mul_rsp.done) begin
                        a_reg     <= sub_a.val;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= FWD_K;
                    end
                end
                FWD_ADV: begin
                    if (i_reg + 1'b1 < n_reg) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= FWD_INIT;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= SCL;
                    end
                end
                // divide by the pivots
                SCL: begin
                    div_req_reg.a <= sol_reg[ii];
                    state_reg     <= SCL2;
                end
                SCL2: begin
                    div_req_reg.b     <= fac_reg[ii][ii];
                    div_req_reg.start <= 1'b1;
                    state_reg         <= SCL_W;
                end
                SCL_W: begin
                    if (div_rsp.done) begin
                        sol_reg[ii] <= div_rsp.value;
                        if (i_reg + 1'b1 < n_reg) begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= SCL;
                        end else begin
                            i_reg     <= n_reg - 1'b1;
                            state_reg <= BWD_INIT;
                        end
                    end
                end
                // back substitution through L transposed
                BWD_INIT: begin
                    a_reg     <= sol_reg[ii];
                    k_reg     <= i_reg + 1'b1;
                    state_reg <= BWD_K;
                end
                BWD_K: begin
                    if (k_reg < n_reg) begin
                        mul_req_reg.a <= fac_reg[kk][ii];
                        state_reg     <= BWD_K2;
                    end else begin
                        sol_reg[ii] <= a_reg;
                        state_reg   <= BWD_ADV;
                    end
                end
                BWD_K2: begin
                    mul_req_reg.b     <= sol_reg[kk];
                    mul_req_reg.sh32  <= 1'b1;
                    mul_req_reg.start <= 1'b1;
                    state_reg         <= BWD_U;
                end
                BWD_U: begin
                    if (mul_rsp.done) begin
                        a_reg     <= sub_a.val;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= BWD_K;
                    end
                end
                BWD_ADV: begin
                    if (i_reg == '0) begin
                        k_reg     <= '0;
                        state_reg <= EMIT;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= BWD_INIT;
                    end
                end
                EMIT: begin
                    if (out_free) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= sing_reg ? '0 : sol_reg[kk];
                        m_tuser  <= {ovf_reg, sing_reg, k_reg[1:0]};
                        m_tlast  <= (k_reg + 1'b1 == n_reg);
                        if (k_reg + 1'b1 == n_reg) begin
                            ovf_reg <= 1'b0;
                            for (int e = 0; e < NPOW; e++) pow_reg[e] <= '0;
                            for (int e = 0; e < NC; e++) mom_reg[e] <= '0;
                            state_reg <= IDLE;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

/* src/polynomial_least_squares_fit.sv */
// top level of the polynomial least-squares fit: front end, queue, back end, register port
//
// input stream s_*: one (x, y) sample per transaction, Q16.16; s_tlast closes a data set
// output stream m_*: d+1 coefficients in Q32.32 per closed set, lowest power first,
//   with the power in m_tuser, singular and saturated flags, m_tlast on the final one
// register port: fit_degree at byte address 0, degree 0 is taken as 1
// each sample is queued at once (two-entry queue) and accumulated by the back end in
//   3d+1 products, all on the one shared 64x64 multiplier that builds each product from
//   four 32x32 partial products
// the solve after a closing sample runs n(n-1)/2 quotients for L plus n for the pivots
//   through the bit-serial divider, and its products through the multiplier
// results appear in order through a single output register; a stalled receiver holds the
//   back end once it has a coefficient to emit, while the queue goes on taking samples until it is full
// reset (aresetn low, synchronous) clears all sums, flags and transactions in flight
//   and sets fit_degree to 1
module polynomial_least_squares_fit #(
    parameter int MAX_DEGREE = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_x [31:0], sample_y [63:32]
    input  logic        s_tlast,   // last_sample
    // coefficient output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // coeff_value [63:0]
    output logic [3:0]  m_tuser,   // coeff_index [1:0], singular [2], saturated [3]
    output logic        m_tlast,   // last_coeff
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] degree_reg;
    logic [1:0] eff_degree;
    plsf_pkg::sample_t front_item, q_item;
    logic q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == plsf_pkg::REG_FIT_DEGREE) ? {30'd0, degree_reg} : 32'd0;

    // degree register, written on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= 2'd1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == plsf_pkg::REG_FIT_DEGREE) begin
            degree_reg <= pwdata[1:0];
        end
    end

    // front end: classify each sample with the degree it arrived under
    always_comb begin
        if (degree_reg == 2'd0) begin
            eff_degree = 2'd1;
        end else if (32'(degree_reg) > MAX_DEGREE) begin
            eff_degree = 2'(MAX_DEGREE);
        end else begin
            eff_degree = degree_reg;
        end
        front_item.x      = s_tdata[31:0];
        front_item.y      = s_tdata[63:32];
        front_item.last   = s_tlast;
        front_item.degree = eff_degree;
    end

    plsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_item)
    );

    plsf_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // a singular system reports zero for every coefficient
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == 64'd0))
        else $error("singular result with non-zero coefficient");

    // a full queue always has something for the back end
    a_full_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("queue refuses samples while empty");

    // checks that nothing follows the final coefficient at once; a next set already waiting in EMIT breaks this
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result straight after the final coefficient");

    // nothing is offered in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered straight after reset");
`endif

endmodule
